// ===== sv/phm_pkg.sv =====
// Shared types and constants for the ping history median RTT unit.
// Holds widths, opcodes, register indexes, sequencer states and the cell structs.
// No dependencies; every other file imports it.
package phm_pkg;

  // Window size and the widths that follow from it.
  localparam int HISTORY_DEPTH = 8;
  localparam int AGE_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  // Field widths of the item payloads.
  localparam int OP_W        = 2;
  localparam int SEQ_W       = 16;
  localparam int RTT_W       = 32;
  localparam int COUNT_OUT_W = 4;
  localparam int LOST_W      = 18;
  localparam int LIMIT_W     = 7;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_ESTIMATE = 1'b1;
  localparam logic [LIMIT_W-1:0]   LOSS_LIMIT_RESET  = 7'd3;
  localparam logic [RTT_W-1:0]     NO_ESTIMATE_RESET = 32'd10000000;

  // Opcodes of an input item; the unused code acts as a query.
  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Age of the entry that falls out of a full window.
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(HISTORY_DEPTH);

  // One cell of the sorted row: round-trip time, sequence number, age.
  typedef struct packed {
    logic [RTT_W-1:0] rtt;
    logic [SEQ_W-1:0] seq;
    logic [AGE_W-1:0] age;
  } cell_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic             evict;
    logic             insert;
    logic [RTT_W-1:0] rtt;
    logic [SEQ_W-1:0] seq;
  } chain_cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVICT  = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_RESULT = 4'b1000
  } phm_state_t;

endpackage

// ===== sv/phm_cell.sv =====
// One cell of the sorted RTT row: holds one sample and its age.
// Talks only to its left and right neighbors; depends on phm_pkg.
// Evict shifts entries toward the head, insert shifts them toward the tail.
module phm_cell (
  input  logic               clk,
  input  phm_pkg::chain_cmd_t cmd,
  input  logic               occupied,
  input  phm_pkg::cell_t      left,
  input  logic               left_greater,
  input  logic               left_del,
  input  phm_pkg::cell_t      right,
  output phm_pkg::cell_t      entry,
  output logic               greater,
  output logic               del_seen
);
  import phm_pkg::*;

  cell_t entry_next;
  logic  hit;

  // Neighbor flags: the eviction point seen so far, and whether this cell
  // sorts after the incoming sample.
  always_comb begin
    hit      = occupied && (entry.age == AGE_OLDEST);
    del_seen = left_del || hit;
    greater  = !occupied || (entry.rtt > cmd.rtt);
  end

  // Next content of the cell.
  always_comb begin
    entry_next = entry;
    if (cmd.evict) begin
      if (del_seen) begin
        entry_next = right;
      end
    end else if (cmd.insert) begin
      if (left_greater) begin
        entry_next     = left;
        entry_next.age = left.age + 1'b1;
      end else if (greater) begin
        entry_next.rtt = cmd.rtt;
        entry_next.seq = cmd.seq;
        entry_next.age = '0;
      end else begin
        entry_next.age = entry.age + 1'b1;
      end
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== sv/phm_chain.sv =====
// Row of sorted cells and the selection of median, oldest and newest entry.
// Instantiates phm_cell HISTORY_DEPTH times; depends on phm_pkg.
// Cells below the fill count are held, in ascending RTT order.
module phm_chain (
  input  logic                        clk,
  input  phm_pkg::chain_cmd_t          cmd,
  input  logic [phm_pkg::CNT_W-1:0]   fill,
  output logic [phm_pkg::RTT_W-1:0]   mid_rtt,
  output logic [phm_pkg::SEQ_W-1:0]   oldest_seq,
  output logic [phm_pkg::SEQ_W-1:0]   newest_seq
);
  import phm_pkg::*;

  cell_t            entries  [HISTORY_DEPTH];
  logic             occ      [HISTORY_DEPTH];
  logic             gt_chain [HISTORY_DEPTH+1];
  logic             del_chain[HISTORY_DEPTH+1];
  logic [AGE_W-1:0] med_idx;
  logic [AGE_W-1:0] oldest_age;

  assign gt_chain[0]  = 1'b0;
  assign del_chain[0] = 1'b0;

  // The row of cells, each wired to its two neighbors.
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    cell_t left_entry;
    cell_t right_entry;

    assign occ[i]      = (CNT_W'(i) < fill);
    assign left_entry  = (i == 0) ? entries[0] : entries[(i == 0) ? 0 : i - 1];
    assign right_entry = entries[(i == HISTORY_DEPTH - 1) ? i : i + 1];

    phm_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .occupied     (occ[i]),
      .left         (left_entry),
      .left_greater (gt_chain[i]),
      .left_del     (del_chain[i]),
      .right        (right_entry),
      .entry        (entries[i]),
      .greater      (gt_chain[i+1]),
      .del_seen     (del_chain[i+1])
    );
  end

  // Upper median sits at rank fill/2 of the sorted row.
  assign med_idx    = AGE_W'(fill >> 1);
  assign mid_rtt    = entries[med_idx].rtt;
  assign oldest_age = AGE_W'(fill - 1'b1);

  // Oldest and newest sample are found by their ages.
  always_comb begin
    oldest_seq = '0;
    newest_seq = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (occ[i] && (entries[i].age == oldest_age)) begin
        oldest_seq = oldest_seq | entries[i].seq;
      end
      if (occ[i] && (entries[i].age == '0)) begin
        newest_seq = newest_seq | entries[i].seq;
      end
    end
  end

endmodule

// ===== sv/ping_history_median_rtt_unit.sv =====
// Top level of the ping history median RTT unit: sequencer, counters,
// configuration registers and output register. Depends on phm_pkg, phm_chain.
//
//   channel  | direction | fields (lowest bit first)
//   s_t*     | in        | opcode, sample_seq, sample_rtt
//   m_t*     | out       | rtt_estimate, sample_count, lost_count, too_lossy,
//            |           | history_empty
//   cfg_*    | in        | loss_limit (index 0), no_estimate_value (index 1)
//
// A record item makes an eviction pass and an insertion pass through the cell
// row in the evict and insert states; its result is then registered in the
// result state. Query and clear go straight to the result state. The next
// item is accepted once the result is registered.
// Reset is synchronous and restores the empty history and register defaults.
// A stalled result holds the output register and delays the next item.
module ping_history_median_rtt_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [phm_pkg::IN_TDATA_W-1:0]      s_tdata,   // opcode, sample_seq, sample_rtt
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [phm_pkg::OUT_TDATA_W-1:0]     m_tdata,   // rtt_estimate, sample_count,
                                                         // lost_count, too_lossy,
                                                         // history_empty
  input  logic                                cfg_we,
  input  logic [phm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [phm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import phm_pkg::*;

  phm_state_t        state;
  phm_state_t        state_next;
  logic [CNT_W-1:0]  held_count;
  logic [CNT_W-1:0]  held_count_next;
  logic [LIMIT_W-1:0] loss_limit;
  logic [RTT_W-1:0]  no_estimate_value;
  logic [RTT_W-1:0]  item_rtt;
  logic [SEQ_W-1:0]  item_seq;
  logic              accept;
  logic [OP_W-1:0]   in_opcode;
  logic              out_load;
  chain_cmd_t        cmd;
  logic [RTT_W-1:0]  mid_rtt;
  logic [SEQ_W-1:0]  oldest_seq;
  logic [SEQ_W-1:0]  newest_seq;
  logic              empty;
  logic [LOST_W-1:0] lost;
  logic              lossy;
  logic [RTT_W-1:0]  estimate;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_opcode = s_tdata[OP_W-1:0];
  assign out_load  = (state == ST_RESULT) && (!m_tvalid || m_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_limit        <= LOSS_LIMIT_RESET;
      no_estimate_value <= NO_ESTIMATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOSS_LIMIT:  loss_limit        <= cfg_data[LIMIT_W-1:0];
        REG_NO_ESTIMATE: no_estimate_value <= cfg_data[RTT_W-1:0];
        default:         loss_limit        <= loss_limit;
      endcase
    end
  end

  // Latch the sample of an accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_seq <= s_tdata[OP_W+SEQ_W-1:OP_W];
      item_rtt <= s_tdata[OP_W+SEQ_W+RTT_W-1:OP_W+SEQ_W];
    end
  end

  // Sequencer and fill count.
  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_RECORD: state_next = ST_EVICT;
            OP_CLEAR: begin
              state_next      = ST_RESULT;
              held_count_next = '0;
            end
            OP_QUERY: state_next = ST_RESULT;
            default:  state_next = ST_RESULT;
          endcase
        end
      end
      ST_EVICT: begin
        state_next = ST_INSERT;
        if (held_count == COUNT_FULL) begin
          held_count_next = held_count - 1'b1;
        end
      end
      ST_INSERT: begin
        state_next      = ST_RESULT;
        held_count_next = held_count + 1'b1;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
    end
  end

  // Command to the cell row.
  always_comb begin
    cmd.evict  = (state == ST_EVICT);
    cmd.insert = (state == ST_INSERT);
    cmd.rtt    = item_rtt;
    cmd.seq    = item_seq;
  end

  phm_chain u_chain (
    .clk        (clk),
    .cmd        (cmd),
    .fill       (held_count),
    .mid_rtt    (mid_rtt),
    .oldest_seq (oldest_seq),
    .newest_seq (newest_seq)
  );

  // Lost count, loss test and estimate.
  always_comb begin
    empty    = (held_count == '0);
    lost     = '0;
    lossy    = 1'b0;
    estimate = no_estimate_value;
    if (!empty) begin
      lost = LOST_W'(newest_seq) - LOST_W'(oldest_seq) - LOST_W'(held_count - 1'b1);
      lossy = ($signed(lost) > $signed(LOST_W'(loss_limit)));
      if (!lossy) begin
        estimate = mid_rtt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {empty, lossy, lost, COUNT_OUT_W'(held_count), estimate};
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the window size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_FULL)
    else $error("held_count beyond window size");

  // A clear item empties the history at once.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_opcode == OP_CLEAR)) |=> (held_count == '0))
    else $error("clear did not empty the history");

  // A record item starts with the eviction pass.
  a_record_evicts: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_opcode == OP_RECORD)) |=> (state == ST_EVICT))
    else $error("record item skipped the eviction pass");

  // The empty flag agrees with the reported count, and empty means no loss.
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[55] == (m_tdata[35:32] == '0)) &&
                  (!m_tdata[55] || ((m_tdata[53:36] == '0) && !m_tdata[54]))))
    else $error("empty flag inconsistent with count or loss");
`endif

endmodule

// ===== tb/tb_ping_history_median_rtt_unit.sv =====
// Self-checking bench for the ping history median RTT unit: directed and random items
// over the stream ports, checked against an in-bench model of the sample window.
// Depends on phm_pkg and ping_history_median_rtt_unit.
module tb_ping_history_median_rtt_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import phm_pkg::*;

  // The unused opcode behaves as a query.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int CHUNK_ITEMS = 50;
  localparam int CHUNKS_PER_PHASE = 5;
  localparam int PHASES = 5;

  // One input item, opcode in the lowest bits.
  typedef struct packed {
    logic [RTT_W-1:0] rtt;
    logic [SEQ_W-1:0] seq;
    logic [OP_W-1:0]  op;
  } ping_item_t;

  // One result item, estimate in the lowest bits.
  typedef struct packed {
    logic                     empty;
    logic                     lossy;
    logic signed [LOST_W-1:0] lost;
    logic [COUNT_OUT_W-1:0]   count;
    logic [RTT_W-1:0]         estimate;
  } ping_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // opcode, sample_seq, sample_rtt
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // rtt_estimate, sample_count, lost_count,
                                          // too_lossy, history_empty
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Window model: ring of held samples plus the two registers.
  logic [RTT_W-1:0]   win_rtt [HISTORY_DEPTH];
  logic [SEQ_W-1:0]   win_seq [HISTORY_DEPTH];
  int                 win_slot = 0;
  int                 win_held = 0;
  logic [LIMIT_W-1:0] win_loss_limit = LOSS_LIMIT_RESET;
  logic [RTT_W-1:0]   win_no_estimate = NO_ESTIMATE_RESET;

  ping_item_t   ping_items [$];
  ping_result_t expected_estimates [$];
  int           items_issued = 0;
  int           results_checked = 0;
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           ready_stall_pct = 0;
  int           hold_requests = 0;
  int           holds_served = 0;
  int           hold_left = 0;

  ping_history_median_rtt_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one item to the window model and return the estimate it should produce.
  function automatic ping_result_t window_estimate(ping_item_t it);
    logic [RTT_W-1:0] sorted [HISTORY_DEPTH];
    logic [RTT_W-1:0] v;
    int               oldest;
    int               newest;
    int               lost_sum;
    int               j;
    ping_result_t     r;
    if (it.op == OP_RECORD) begin
      win_seq[win_slot] = it.seq;
      win_rtt[win_slot] = it.rtt;
      win_slot = (win_slot + 1) % HISTORY_DEPTH;
      if (win_held < HISTORY_DEPTH) win_held++;
    end else if (it.op == OP_CLEAR) begin
      win_slot = 0;
      win_held = 0;
    end
    r.estimate = win_no_estimate;
    r.count    = COUNT_OUT_W'(win_held);
    r.lost     = '0;
    r.lossy    = 1'b0;
    r.empty    = (win_held == 0);
    if (win_held != 0) begin
      oldest   = (win_slot + HISTORY_DEPTH - win_held) % HISTORY_DEPTH;
      newest   = (win_slot + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
      // Summed gaps collapse to newest minus oldest minus the expected steps.
      lost_sum = int'(win_seq[newest]) - int'(win_seq[oldest]) - (win_held - 1);
      r.lost   = lost_sum[LOST_W-1:0];
      if (lost_sum > int'(win_loss_limit)) begin
        r.lossy = 1'b1;
      end else begin
        // Until the ring fills, the held samples sit in the lowest slots.
        for (int i = 0; i < win_held; i++) sorted[i] = win_rtt[i];
        for (int i = 1; i < win_held; i++) begin
          v = sorted[i];
          j = i;
          while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = v;
        end
        r.estimate = sorted[win_held / 2];
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Driver: offers the next pending item, with random idle cycles.
  always @(posedge clk) begin : driver
    ping_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (ping_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = ping_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(it);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Monitor: predicts on each accepted input item, checks each accepted result.
  always @(posedge clk) begin : monitor
    ping_result_t want;
    ping_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_estimates.push_back(
          window_estimate(ping_item_t'(s_tdata[$bits(ping_item_t)-1:0])));
      if (m_tvalid && m_tready) begin
        got = ping_result_t'(m_tdata);
        if (expected_estimates.size() == 0) begin
          $error("result with no item pending: %h", m_tdata);
          error_count++;
        end else begin
          want = expected_estimates.pop_front();
          check_field("rtt_estimate", want.estimate, got.estimate);
          check_field("sample_count", want.count, got.count);
          check_field("lost_count", want.lost, got.lost);
          check_field("too_lossy", want.lossy, got.lossy);
          check_field("history_empty", want.empty, got.empty);
          results_checked++;
        end
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                           input logic [RTT_W-1:0] rtt);
    ping_item_t it;
    it.op  = op;
    it.seq = seq;
    it.rtt = rtt;
    ping_items.push_back(it);
    items_issued++;
  endtask

  task automatic wait_for_results();
    while (results_checked != items_issued) @(posedge clk);
  endtask

  // Register write; the window model takes the same value.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOSS_LIMIT) win_loss_limit = val[LIMIT_W-1:0];
    else win_no_estimate = val;
  endtask

  // Mostly runs of replies with small sequence steps, with some jumps,
  // backward steps, queries, clears and the unused opcode.
  task automatic queue_random_items(input int count, inout logic [SEQ_W-1:0] next_seq);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] seq;
    logic [RTT_W-1:0] rtt;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 78) op = OP_RECORD;
      else if (pick < 90) op = OP_QUERY;
      else if (pick < 95) op = OP_CLEAR;
      else op = OP_UNUSED;
      seq = SEQ_W'($urandom);
      rtt = $urandom;
      if (op == OP_RECORD) begin
        pick = $urandom_range(99);
        if (pick < 65) next_seq = next_seq + 1'b1;
        else if (pick < 85) next_seq = next_seq + SEQ_W'(1 + $urandom_range(1, 4));
        else if (pick < 92) next_seq = next_seq;
        else if (pick < 96) next_seq = next_seq - SEQ_W'($urandom_range(1, 5));
        else next_seq = SEQ_W'($urandom);
        seq  = next_seq;
        // Small values give ties in the sort; some others sit near the top.
        pick = $urandom_range(99);
        if (pick < 35) rtt = $urandom_range(0, 7);
        else if (pick < 45) rtt = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end
      send_item(op, seq, rtt);
    end
  endtask

  // Stimulus: directed items at reset settings, then random phases.
  initial begin
    logic [SEQ_W-1:0] next_seq;
    next_seq = SEQ_W'($urandom);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty history with every opcode.
    send_item(OP_QUERY, 16'h0000, 32'h0000_0000);
    send_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 16'h1234, 32'h0000_0005);
    // Extreme round-trip times, then fill and wrap the ring.
    send_item(OP_RECORD, 16'd0, 32'h0000_0000);
    send_item(OP_RECORD, 16'd1, 32'hFFFF_FFFF);
    send_item(OP_RECORD, 16'd2, 32'h8000_0000);
    send_item(OP_QUERY, 16'hAAAA, 32'h5555_5555);
    for (int k = 3; k <= 8; k++) send_item(OP_RECORD, 16'(k), 32'(100 - k));
    // Lost count equal to the limit, then above it, then negative.
    send_item(OP_RECORD, 16'd12, 32'd7);
    send_item(OP_RECORD, 16'd17, 32'd7);
    send_item(OP_RECORD, 16'd0, 32'd9);
    // Wrapped sequence numbers give the most negative lost count.
    send_item(OP_CLEAR, 16'h5555, 32'hAAAA_AAAA);
    send_item(OP_RECORD, 16'hFFFF, 32'd1);
    for (int k = 0; k < 7; k++) send_item(OP_RECORD, 16'd0, 32'(k));
    wait_for_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_LOSS_LIMIT, 32'd0);
          write_reg(REG_NO_ESTIMATE, 32'd0);
          send_idle_pct   = 0;
          ready_stall_pct = 0;
        end
        1: begin
          write_reg(REG_LOSS_LIMIT, 32'd127);
          write_reg(REG_NO_ESTIMATE, 32'hFFFF_FFFF);
          send_idle_pct   = 49;
          ready_stall_pct = 0;
        end
        2: begin
          // Bits above the register width are dropped.
          write_reg(REG_LOSS_LIMIT, 32'hFFFF_FF85);
          write_reg(REG_NO_ESTIMATE, $urandom);
          send_idle_pct   = 0;
          ready_stall_pct = 49;
        end
        3: begin
          write_reg(REG_LOSS_LIMIT, 32'd64);
          write_reg(REG_NO_ESTIMATE, 32'd1);
          send_idle_pct   = 25;
          ready_stall_pct = 25;
        end
        default: begin
          write_reg(REG_LOSS_LIMIT, $urandom_range(0, 8));
          write_reg(REG_NO_ESTIMATE, $urandom);
          send_idle_pct   = 25;
          ready_stall_pct = 25;
        end
      endcase
      // Each chunk drains fully before the next one starts.
      for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
        if (phase == 0 && chunk == 0) hold_requests++;
        queue_random_items(CHUNK_ITEMS, next_seq);
        wait_for_results();
      end
    end

    repeat (8) @(posedge clk);
    if (expected_estimates.size() != 0) begin
      $error("%0d expected results never arrived", expected_estimates.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ping_history_median_rtt_unit] OK");
    end else begin
      $display("[ping_history_median_rtt_unit] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("[ping_history_median_rtt_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/phm_pkg.sv
sv/phm_cell.sv
sv/phm_chain.sv
sv/ping_history_median_rtt_unit.sv
tb/tb_ping_history_median_rtt_unit.sv
